### src/irf_pkg.sv
// Package for the image rotate/flip address core: widths, codes, queue entry type.
// Standalone; used by every module under src.
package irf_pkg;

  localparam int MAX_SIDE = 2048;
  localparam int SIDE_W   = 12;   // width/height register and side value
  localparam int CNT_W    = 11;   // column/row counters
  localparam int IDX_W    = 22;   // destination index
  localparam int PIX_W    = 32;
  localparam int MODE_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W   = CNT_W + SIDE_W;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE    = 3'd0,
    MODE_HMIRROR = 3'd1,
    MODE_VFLIP   = 3'd2,
    MODE_CW      = 3'd3,
    MODE_CCW     = 3'd4,
    MODE_R180    = 3'd5
  } rot_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } cfg_reg_t;

  // One classified request: dest_index = add_term + mul_a * mul_b
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [CNT_W-1:0]  add_term;
    logic [CNT_W-1:0]  mul_a;
    logic [SIDE_W-1:0] mul_b;
    logic              last;
  } irf_entry_t;

  // Zero reads as 1, anything above MAX_SIDE saturates.
  function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] r);
    logic [SIDE_W-1:0] s;
    if (r == '0) begin
      s = SIDE_W'(1);
    end else if (r > SIDE_W'(MAX_SIDE)) begin
      s = SIDE_W'(MAX_SIDE);
    end else begin
      s = r;
    end
    return s;
  endfunction

endpackage

### src/image_rotate_flip_address_core.sv
// Image rotate/flip address core: source pixels in raster order in, destination index out.
// Path from request accept to out_valid: queue write on accept, multiply register, add/output register.
// Throughput: 1 request per cycle unless the output stalls; the single 11x12 multiplier stage sets the pace.
// Mode none consumes requests with no result. 4-entry queue absorbs output stalls.
// Reset (rst, synchronous): width/height 1, mode none, counters zero, pipeline empty.
// Depends on irf_pkg, irf_front, irf_queue, irf_back.
module image_rotate_flip_address_core
  import irf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel: 0 width, 1 height, 2 mode
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIDE_W-1:0]    cfg_data,
  // source pixel requests
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     pixel_in,
  // destination requests
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     dest_index,
  output logic [PIX_W-1:0]     pixel_out,
  output logic                 frame_last
);

  irf_entry_t push_entry, head;
  logic       push, pop, q_full, q_not_empty;

  // Registers are always writable; writes must only be issued while idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;
  // Front stalls only on a full queue, never on the output side directly.
  assign in_stall  = q_full;

  irf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .q_full     (q_full),
    .pixel_in   (pixel_in),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples classification from the multiply/add pipe
  irf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (q_not_empty),
    .full       (q_full)
  );

  irf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .not_empty  (q_not_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dest_index (dest_index),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

endmodule

### src/irf_front.sv
// Front end: configuration registers, column/row counters and mode classification.
// Depends on irf_pkg; feeds irf_queue.
module irf_front
  import irf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIDE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 q_full,
  input  logic [PIX_W-1:0]     pixel_in,
  output logic                 push,
  output irf_entry_t           push_entry
);

  logic [SIDE_W-1:0] image_width;
  logic [SIDE_W-1:0] image_height;
  logic [MODE_W-1:0] rotate_mode;
  logic [CNT_W-1:0]  column_count, column_count_next;
  logic [CNT_W-1:0]  row_count, row_count_next;

  logic [SIDE_W-1:0] w, h, w_m1, h_m1;
  logic [CNT_W-1:0]  xr, yr;
  logic              x_end, y_end, emit, accept;

  assign w      = side_of(image_width);
  assign h      = side_of(image_height);
  assign w_m1   = w - SIDE_W'(1);
  assign h_m1   = h - SIDE_W'(1);
  assign xr     = w_m1[CNT_W-1:0] - column_count;
  assign yr     = h_m1[CNT_W-1:0] - row_count;
  assign x_end  = ({1'b0, column_count} + SIDE_W'(1)) >= w;
  assign y_end  = ({1'b0, row_count} + SIDE_W'(1)) >= h;
  assign accept = in_valid && !q_full;

  always_comb begin
    emit                = 1'b1;
    push_entry.pixel    = pixel_in;
    push_entry.last     = x_end && y_end;
    push_entry.add_term = xr;
    push_entry.mul_a    = row_count;
    push_entry.mul_b    = w;
    unique case (rotate_mode)
      MODE_HMIRROR: begin
        push_entry.add_term = xr;
        push_entry.mul_a    = row_count;
        push_entry.mul_b    = w;
      end
      MODE_VFLIP: begin
        push_entry.add_term = column_count;
        push_entry.mul_a    = yr;
        push_entry.mul_b    = w;
      end
      MODE_CW: begin
        push_entry.add_term = yr;
        push_entry.mul_a    = column_count;
        push_entry.mul_b    = h;
      end
      MODE_CCW: begin
        push_entry.add_term = row_count;
        push_entry.mul_a    = xr;
        push_entry.mul_b    = h;
      end
      MODE_R180: begin
        push_entry.add_term = xr;
        push_entry.mul_a    = yr;
        push_entry.mul_b    = w;
      end
      default: begin
        emit = 1'b0;  // none and undefined codes: counters only
      end
    endcase
  end

  assign push = accept && emit;

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (accept) begin
      if (x_end) begin
        column_count_next = '0;
        row_count_next    = y_end ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count_next = column_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIDE_W'(1);
      image_height <= SIDE_W'(1);
      rotate_mode  <= MODE_NONE;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH: begin
          image_width  <= cfg_data;
          column_count <= '0;
          row_count    <= '0;
        end
        REG_HEIGHT: begin
          image_height <= cfg_data;
          column_count <= '0;
          row_count    <= '0;
        end
        REG_MODE: begin
          rotate_mode  <= cfg_data[MODE_W-1:0];
          column_count <= '0;
          row_count    <= '0;
        end
        default: begin
          column_count <= column_count_next;
          row_count    <= row_count_next;
        end
      endcase
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

### src/irf_queue.sv
// Short FIFO of classified requests between front and back ends.
// Depends on irf_pkg.
module irf_queue
  import irf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  irf_entry_t push_entry,
  input  logic       pop,
  output irf_entry_t head,
  output logic       not_empty,
  output logic       full
);

  irf_entry_t        slots [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;

  assign head      = slots[rptr];
  assign not_empty = count != '0;
  assign full      = count == QCNT_W'(QDEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### src/irf_back.sv
// Back end: multiply stage then add into the output register.
// Depends on irf_pkg; drains irf_queue.
module irf_back
  import irf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  irf_entry_t       head,
  input  logic             not_empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IDX_W-1:0] dest_index,
  output logic [PIX_W-1:0] pixel_out,
  output logic             frame_last
);

  logic              advance;
  logic              s1_valid;
  logic [PROD_W-1:0] s1_prod;
  logic [CNT_W-1:0]  s1_add;
  logic [PIX_W-1:0]  s1_pixel;
  logic              s1_last;

  // whole pipe moves unless the output holds an unaccepted result
  assign advance = !out_valid || !out_stall;
  assign pop     = advance && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= not_empty;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_prod    <= PROD_W'(head.mul_a) * PROD_W'(head.mul_b);
      s1_add     <= head.add_term;
      s1_pixel   <= head.pixel;
      s1_last    <= head.last;
      dest_index <= s1_prod[IDX_W-1:0] + IDX_W'(s1_add);
      pixel_out  <= s1_pixel;
      frame_last <= s1_last;
    end
  end

endmodule

### src/irf_checker.sv
// Port-level checks for the image rotate/flip address core, bound to the top level.
// Depends on irf_pkg.
module irf_checker
  import irf_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [IDX_W-1:0]     dest_index,
  input logic [PIX_W-1:0]     pixel_out,
  input logic                 frame_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dest_index) && $stable(pixel_out)
      && $stable(frame_last))
    else $error("stalled result changed");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // queue can only be full if the output was stalled last cycle
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // config port always writable
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind image_rotate_flip_address_core irf_checker u_irf_checker (.*);
